/* src/nir_pkg.sv */
// shared types and widths for the newton square root refinement pipeline
`default_nettype none
package nir_pkg;
  localparam int unsigned DataW  = 63;
  localparam int unsigned CountW = 4;

  typedef logic [DataW-1:0]  data_t;
  typedef logic [CountW-1:0] count_t;

  typedef struct packed {
    data_t  x;
    data_t  e;
    data_t  rem;
    data_t  quo;
    count_t n;
  } item_t;
endpackage
`default_nettype wire

/* src/nir_if.sv */
// item channels for operands, roots and the round count register
`default_nettype none
interface nir_in_if;
  logic            valid;
  logic            ready;
  nir_pkg::data_t  operand;
  nir_pkg::data_t  seed;
  modport source (output valid, output operand, output seed, input ready);
  modport sink   (input valid, input operand, input seed, output ready);
endinterface

interface nir_out_if;
  logic            valid;
  logic            ready;
  nir_pkg::data_t  root;
  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

interface nir_cfg_if;
  logic            valid;
  logic            ready;
  nir_pkg::count_t round_count;
  modport source (output valid, output round_count, input ready);
  modport sink   (input valid, input round_count, output ready);
endinterface
`default_nettype wire

/* src/nir_divider.sv */
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module nir_divider (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire nir_pkg::item_t in_item,
  output logic                out_valid,
  output nir_pkg::item_t      out_item
);
  import nir_pkg::*;

  logic  [DataW-1:0] v_r;
  item_t             d_r [DataW];
  item_t             d_nxt [DataW];

  for (genvar j = 0; j < DataW; j++) begin : g_stage
    item_t        prev;
    logic [DataW:0] rem2;
    logic [DataW:0] diff;
    logic         ge;

    always_comb begin
      prev      = (j == 0) ? in_item : d_r[(j == 0) ? 0 : j-1];
      rem2      = {prev.rem, prev.x[DataW-1-j]};
      diff      = rem2 - {1'b0, prev.e};
      ge        = (rem2 >= {1'b0, prev.e});
      d_nxt[j]      = prev;
      d_nxt[j].rem  = ge ? diff[DataW-1:0] : rem2[DataW-1:0];
      d_nxt[j].quo  = {prev.quo[DataW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= (j == 0) ? in_valid : v_r[(j == 0) ? 0 : j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[j] <= d_nxt[j];
      end
    end
  end

  assign out_valid = v_r[DataW-1];
  assign out_item  = d_r[DataW-1];
endmodule
`default_nettype wire

/* src/newton_isqrt_refine_unit.sv */
// newton square root refinement: top level with unrolled pipelined rounds
// throughput: one item per cycle while not stalled; each division is a 63-stage bit pipeline
// the whole pipeline advances when the output register is empty or taken
// reset clears all valid bits and sets round_count to 3
`default_nettype none
module newton_isqrt_refine_unit #(
  parameter int unsigned MAX_ROUNDS = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  nir_in_if.sink    in_ch,
  nir_out_if.source out_ch,
  nir_cfg_if.sink   cfg_ch
);
  import nir_pkg::*;

  localparam count_t RoundReset = count_t'(3);

  count_t round_count_r;
  logic   en;
  logic   out_valid_r;
  data_t  root_r;

  logic   st_v    [MAX_ROUNDS+1];
  item_t  st_item [MAX_ROUNDS+1];

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r <= RoundReset;
    end else if (cfg_ch.valid) begin
      round_count_r <= cfg_ch.round_count;
    end
  end

  assign st_v[0]    = in_ch.valid;
  assign st_item[0] = '{x: in_ch.operand, e: in_ch.seed, rem: '0, quo: '0, n: round_count_r};

  for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_round
    localparam logic [6:0] Idx = 7'(k);
    logic  dv;
    item_t di;
    item_t up_nxt;
    data_t q;
    logic [DataW:0] sum;
    logic  v_r;
    item_t up_r;

    nir_divider u_div (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(st_v[k]), .in_item(st_item[k]),
      .out_valid(dv), .out_item(di)
    );

    always_comb begin
      q          = (di.e == '0) ? di.x : di.quo;
      sum        = {1'b0, di.e} + {1'b0, q};
      up_nxt     = di;
      up_nxt.rem = '0;
      up_nxt.quo = '0;
      if (Idx < {3'b000, di.n}) begin
        up_nxt.e = sum[DataW:1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= dv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        up_r <= up_nxt;
      end
    end

    assign st_v[k+1]    = v_r;
    assign st_item[k+1] = up_r;
  end

  logic  fv;
  item_t fi;
  data_t fq;

  nir_divider u_div_final (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(st_v[MAX_ROUNDS]), .in_item(st_item[MAX_ROUNDS]),
    .out_valid(fv), .out_item(fi)
  );

  assign fq = (fi.e == '0) ? fi.x : fi.quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= (fq < fi.e) ? (fi.e - data_t'(1)) : fi.e;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.root  = root_r;
endmodule
`default_nettype wire

/* test/newton_isqrt_refine_unit_tb.sv */
// self-checking testbench for the newton square root refinement unit
`timescale 1ns / 100ps
`default_nettype none
module newton_isqrt_refine_unit_tb;
  import nir_pkg::*;

  localparam int unsigned MaxRounds = 8;
  localparam int unsigned Latency   = (MaxRounds + 1) * 64;
  localparam longint unsigned CycleLimit = 400000;
  localparam int unsigned NumRandom = 1400;
  localparam data_t DataMax = {DataW{1'b1}};

  typedef struct {
    data_t  operand;
    data_t  seed;
    count_t rounds;
    bit     known;
    data_t  root;
  } vec_t;

  logic clk;
  logic rst_n;

  nir_in_if  in_ch ();
  nir_out_if out_ch ();
  nir_cfg_if cfg_ch ();

  newton_isqrt_refine_unit #(.MAX_ROUNDS(MaxRounds)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  count_t          round_setting;
  data_t           roots_pending[$];
  int unsigned     error_count;
  longint unsigned cycle_count = 0;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  vec_t            directed[$];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic data_t quotient(data_t x, data_t e);
    if (e == '0) begin
      return x;
    end
    return x / e;
  endfunction

  function automatic data_t refine_root(data_t x, data_t seed, count_t rounds);
    data_t          e;
    logic [DataW:0] sum;
    int unsigned    n;
    e = seed;
    n = (rounds > MaxRounds) ? MaxRounds : rounds;
    for (int unsigned i = 0; i < n; i++) begin
      sum = {1'b0, e} + {1'b0, quotient(x, e)};
      e = sum[DataW:1];
    end
    if (quotient(x, e) < e) begin
      e = e - 1'b1;
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, data_t got, data_t want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (roots_pending.size() == 0) begin
        report_mismatch("unexpected root", out_ch.root, '0);
      end else begin
        if (out_ch.root !== roots_pending[0]) begin
          report_mismatch("root", out_ch.root, roots_pending[0]);
        end
        void'(roots_pending.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_rounds(count_t value);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.round_count <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    round_setting = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_item(vec_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.operand <= v.operand;
    in_ch.seed    <= v.seed;
    do @(posedge clk); while (!in_ch.ready);
    roots_pending.push_back(v.known ? v.root : refine_root(v.operand, v.seed, round_setting));
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (roots_pending.size() != 0) @(negedge clk);
    repeat (Latency + 10) @(negedge clk);
  endtask

  function automatic data_t rand_data();
    data_t v;
    v = data_t'({$urandom, $urandom});
    case ($urandom_range(3))
      0: v = v >> $urandom_range(DataW - 1);
      1: v = {31'd0, v[31:0]};
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    vec_t v;
    data_t x;
    count_t phase_rounds[3];
    rst_n = 1'b0;
    error_count = 0;
    send_idle_pct = 14;
    recv_idle_pct = 78;
    round_setting = 4'd3;
    in_ch.valid = 1'b0;
    in_ch.operand = '0;
    in_ch.seed = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.round_count = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // operand, seed, rounds (unused here), known, root
    directed = '{
      '{63'd0, 63'd0, 4'd0, 1'b1, 63'd0},
      '{63'd1, 63'd0, 4'd0, 1'b0, 63'd0},
      '{63'd100, 63'd10, 4'd0, 1'b1, 63'd10},
      '{63'd99, 63'd10, 4'd0, 1'b0, 63'd0},
      '{63'd4, 63'd1, 4'd0, 1'b0, 63'd0},
      '{DataMax, 63'd0, 4'd0, 1'b0, 63'd0},
      '{DataMax, DataMax, 4'd0, 1'b0, 63'd0},
      '{63'd0, DataMax, 4'd0, 1'b0, 63'd0},
      '{DataMax, 63'd3037000499, 4'd0, 1'b0, 63'd0},
      '{63'd1, 63'd1, 4'd0, 1'b0, 63'd0},
      '{63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 4'd0, 1'b0, 63'd0},
      '{63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 4'd0, 1'b0, 63'd0}
    };
    foreach (directed[i]) send_item(directed[i]);
    drain();
    write_rounds(4'd0);
    foreach (directed[i]) begin
      directed[i].known = 1'b0;
      send_item(directed[i]);
    end
    drain();
    write_rounds(4'd15);
    foreach (directed[i]) send_item(directed[i]);
    drain();

    phase_rounds = '{4'd8, 4'd1, 4'd12};
    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin
        send_idle_pct = 78;
        recv_idle_pct = 14;
      end else if (p == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int k = 0; k < 4; k++) begin
        write_rounds((k == 0) ? phase_rounds[p] : count_t'($urandom_range(15)));
        for (int i = 0; i < NumRandom / 12; i++) begin
          x = rand_data();
          v.operand = x;
          v.known = 1'b0;
          case ($urandom_range(3))
            0: v.seed = rand_data();
            1: v.seed = '0;
            default: v.seed = (x >> (DataW / 2)) + $urandom_range(3);
          endcase
          send_item(v);
        end
        drain();
      end
    end

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
